// ----- hdl/bqn_pkg.sv -----
// Shared constants and types for the notch biquad with running normalisation.
// No dependencies; imported by biquad_notch_with_running_normalize.
package bqn_pkg;

  localparam int SAMPLE_W       = 12;
  localparam int COEF_W         = 32;
  localparam int Y_W            = 32;
  localparam int OUT_FRAC_BITS  = 14;
  localparam int MAP_SCALE_LOG2 = 12;
  localparam int MAPPED_W       = MAP_SCALE_LOG2 + 1;

  // digit-serial multiplier: 4-bit digit of the data operand per cycle
  localparam int DIGIT_W   = 4;
  localparam int PP_W      = COEF_W + DIGIT_W + 1;
  localparam int PROD_W    = COEF_W + Y_W;
  localparam int FF_DIGITS = (SAMPLE_W + DIGIT_W - 1) / DIGIT_W;
  localparam int FB_DIGITS = Y_W / DIGIT_W;
  localparam int DCNT_W    = $clog2(FB_DIGITS + 1);

  // accumulator alignment: feed-forward products scaled up, feedback floored
  localparam int FF_SHIFT = OUT_FRAC_BITS - 4;
  localparam int FB_SHIFT = 4;
  localparam int ACC_DROP = 26;
  localparam int ACC_W    = PROD_W + 2;

  localparam int NUM_TERMS = 5;
  localparam int FF_TERMS  = 3;
  localparam int TERM_W    = $clog2(NUM_TERMS);

  localparam int DIV_CNT_W = $clog2(MAPPED_W + 1);
  localparam int REM_W     = Y_W + 1;

  localparam int WARM_W     = 2;
  localparam int WARM_PRIME = 3;

  localparam int TDATA_IN_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_BITS    = MAPPED_W + Y_W;
  localparam int TDATA_OUT_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } cfg_reg_t;

  localparam logic signed [COEF_W-1:0] B0_RESET = 32'sd1057404033;
  localparam logic signed [COEF_W-1:0] B1_RESET = -32'sd2011301992;
  localparam logic signed [COEF_W-1:0] B2_RESET = 32'sd1057404033;
  localparam logic signed [COEF_W-1:0] A1_RESET = 32'sd2011301992;
  localparam logic signed [COEF_W-1:0] A2_RESET = -32'sd1041066242;

  localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
  localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

endpackage

// ----- hdl/biquad_notch_with_running_normalize.sv -----
// Notch biquad (direct form 1, Q2.30 coefficients) with running min/max normalisation.
// Uses bqn_pkg for widths, register codes and reset values.
//
//  channel   | dir | transfer when                 | payload
//  ----------+-----+-------------------------------+--------------------------------------
//  s_axis    | in  | s_axis_tvalid & s_axis_tready | tdata: sample; tuser: block_start
//  m_axis    | out | m_axis_tvalid & m_axis_tready | tdata: mapped, filtered; tuser: flat
//  cfg       | in  | cfg_wr_en                     | cfg_index selects b0,b1,b2,a1,a2
//
//  A dropped or priming sample is finished on acceptance. A filtered sample passes through:
//  accept, 5 products through one 32x4 digit-serial multiplier (3, 3, 3, 8 and 8 digits,
//  each followed by an accumulate step), a rounding step, a restoring divider for the
//  13-bit quotient and a hand-off step; a flat result skips the divider.
//  Reset (rst, synchronous) reloads default coefficients and clears all history.
//  The output register decouples the sides; the hand-off waits only while it is still full.
module biquad_notch_with_running_normalize
  import bqn_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [11:0] sample, rest zero
  input  logic                   s_axis_tuser,   // [0] block_start
  // output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // [12:0] mapped, [44:13] filtered, rest zero
  output logic                   m_axis_tuser,   // [0] flat
  // configuration writes
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COEF_W-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_ROUND,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state;

  // coefficients
  logic signed [COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;

  // filter history and running extremes
  logic [SAMPLE_W-1:0]   prev_sample, prev2_sample, x_cur;
  logic signed [Y_W-1:0] prev_out, prev2_out, run_min, run_max, y_cur;
  logic [WARM_W-1:0]     warmup_count;

  // multiplier / accumulator
  logic [TERM_W-1:0]        term;
  logic [DCNT_W-1:0]        digit_cnt;
  logic                     first_dig;
  logic [Y_W-1:0]           opnd;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  // divider
  logic [REM_W-1:0]     rem;
  logic [Y_W-1:0]       diff_r;
  logic [MAPPED_W-1:0]  quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 flat_r;

  // output register
  logic [MAPPED_W-1:0]   out_mapped;
  logic signed [Y_W-1:0] out_filtered;
  logic                  out_flat;

  // ---------------------------------------------------------------- datapath
  logic signed [COEF_W-1:0] cur_coef;
  logic                     fb_term;
  logic signed [DIGIT_W:0]  dig_s;
  logic signed [PP_W-1:0]   pp;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [ACC_W-1:0]  term_add;
  logic [TERM_W-1:0]        term_next;
  logic [Y_W-1:0]           opnd_load;
  logic [DCNT_W-1:0]        digits_load;

  always_comb begin
    case (term)
      TERM_W'(0): cur_coef = coef_b0;
      TERM_W'(1): cur_coef = coef_b1;
      TERM_W'(2): cur_coef = coef_b2;
      TERM_W'(3): cur_coef = coef_a1;
      default:    cur_coef = coef_a2;
    endcase
  end

  assign fb_term = (term >= TERM_W'(FF_TERMS));

  // leading digit of a signed operand carries the sign; Horner from the top digit down
  assign dig_s     = {fb_term & first_dig & opnd[Y_W-1], opnd[Y_W-1 -: DIGIT_W]};
  assign pp        = PP_W'(cur_coef) * PP_W'(dig_s);
  assign prod_next = first_dig ? PROD_W'(pp) : ((prod <<< DIGIT_W) + PROD_W'(pp));
  assign term_add  = fb_term ? (ACC_W'(prod) >>> FB_SHIFT) : (ACC_W'(prod) <<< FF_SHIFT);

  assign term_next = term + TERM_W'(1);

  always_comb begin
    case (term_next)
      TERM_W'(1): opnd_load = {prev_sample, {(Y_W-SAMPLE_W){1'b0}}};
      TERM_W'(2): opnd_load = {prev2_sample, {(Y_W-SAMPLE_W){1'b0}}};
      TERM_W'(3): opnd_load = prev_out;
      default:    opnd_load = prev2_out;
    endcase
    digits_load = (term_next >= TERM_W'(FF_TERMS)) ? DCNT_W'(FB_DIGITS) : DCNT_W'(FF_DIGITS);
  end

  // round to nearest (ties up), then saturate to 32 bits
  localparam logic signed [ACC_W-1:0] ROUND_BIAS =
    {{(ACC_W-ACC_DROP){1'b0}}, 1'b1, {(ACC_DROP-1){1'b0}}};

  logic signed [ACC_W-1:0] acc_rnd;
  logic                    in_range;
  logic signed [Y_W-1:0]   y_sat, mn_new, mx_new;
  logic signed [Y_W:0]     diff_w, num_w;

  assign acc_rnd  = acc + ROUND_BIAS;
  assign in_range = (&acc_rnd[ACC_W-1:ACC_DROP+Y_W-1]) | ~(|acc_rnd[ACC_W-1:ACC_DROP+Y_W-1]);
  assign y_sat    = in_range ? acc_rnd[ACC_DROP+Y_W-1:ACC_DROP]
                             : (acc_rnd[ACC_W-1] ? Y_MIN : Y_MAX);
  assign mn_new   = (y_sat < run_min) ? y_sat : run_min;
  assign mx_new   = (y_sat > run_max) ? y_sat : run_max;
  assign diff_w   = {mx_new[Y_W-1], mx_new} - {mn_new[Y_W-1], mn_new};
  assign num_w    = {y_sat[Y_W-1], y_sat} - {mn_new[Y_W-1], mn_new};

  // restoring division step; first step takes the numerator unshifted
  logic [REM_W-1:0] rem_sh;
  logic             q_bit;

  assign rem_sh = (div_cnt == DIV_CNT_W'(MAPPED_W)) ? rem : (rem << 1);
  assign q_bit  = (rem_sh >= {1'b0, diff_r});

  // input side
  logic              s_xfer, blk;
  logic [WARM_W-1:0] warm_eff;
  logic [SAMPLE_W-1:0] x_in;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_xfer        = s_axis_tvalid & s_axis_tready;
  assign blk           = s_axis_tuser;
  assign x_in          = s_axis_tdata[SAMPLE_W-1:0];
  assign warm_eff      = blk ? '0 : warmup_count;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      coef_b0       <= B0_RESET;
      coef_b1       <= B1_RESET;
      coef_b2       <= B2_RESET;
      coef_a1       <= A1_RESET;
      coef_a2       <= A2_RESET;
      prev_sample   <= '0;
      prev2_sample  <= '0;
      prev_out      <= '0;
      prev2_out     <= '0;
      run_min       <= '0;
      run_max       <= '0;
      warmup_count  <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_B0:  coef_b0 <= cfg_data;
          REG_B1:  coef_b1 <= cfg_data;
          REG_B2:  coef_b2 <= cfg_data;
          REG_A1:  coef_a1 <= cfg_data;
          REG_A2:  coef_a2 <= cfg_data;
          default: ;
        endcase
      end

      // the hand-off state owns tvalid while it runs
      if (m_axis_tvalid && m_axis_tready && (state != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_xfer) begin
            if (blk) begin
              prev_out  <= '0;
              prev2_out <= '0;
              run_min   <= '0;
              run_max   <= '0;
            end
            if (warm_eff < WARM_W'(WARM_PRIME)) begin
              // dropped or priming sample
              if (blk) begin
                prev_sample  <= '0;
                prev2_sample <= '0;
              end else if (warm_eff != '0) begin
                prev2_sample <= prev_sample;
                prev_sample  <= x_in;
              end
              warmup_count <= warm_eff + WARM_W'(1);
            end else begin
              x_cur     <= x_in;
              opnd      <= {x_in, {(Y_W-SAMPLE_W){1'b0}}};
              digit_cnt <= DCNT_W'(FF_DIGITS);
              first_dig <= 1'b1;
              term      <= '0;
              acc       <= '0;
              state     <= ST_MUL;
            end
          end
        end

        ST_MUL: begin
          prod      <= prod_next;
          first_dig <= 1'b0;
          opnd      <= opnd << DIGIT_W;
          digit_cnt <= digit_cnt - DCNT_W'(1);
          if (digit_cnt == DCNT_W'(1)) begin
            state <= ST_ACC;
          end
        end

        ST_ACC: begin
          acc <= acc + term_add;
          if (term == TERM_W'(NUM_TERMS - 1)) begin
            state <= ST_ROUND;
          end else begin
            term      <= term_next;
            opnd      <= opnd_load;
            digit_cnt <= digits_load;
            first_dig <= 1'b1;
            state     <= ST_MUL;
          end
        end

        ST_ROUND: begin
          y_cur        <= y_sat;
          prev2_sample <= prev_sample;
          prev_sample  <= x_cur;
          prev2_out    <= prev_out;
          prev_out     <= y_sat;
          run_min      <= mn_new;
          run_max      <= mx_new;
          rem          <= {1'b0, num_w[Y_W-1:0]};
          diff_r       <= diff_w[Y_W-1:0];
          quo          <= '0;
          div_cnt      <= DIV_CNT_W'(MAPPED_W);
          if (diff_w == '0) begin
            flat_r <= 1'b1;
            state  <= ST_DONE;
          end else begin
            flat_r <= 1'b0;
            state  <= ST_DIV;
          end
        end

        ST_DIV: begin
          rem     <= q_bit ? (rem_sh - {1'b0, diff_r}) : rem_sh;
          quo     <= {quo[MAPPED_W-2:0], q_bit};
          div_cnt <= div_cnt - DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(1)) begin
            state <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_mapped    <= quo;
            out_filtered  <= y_cur;
            out_flat      <= flat_r;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {{(TDATA_OUT_W-OUT_BITS){1'b0}}, out_filtered, out_mapped};
  assign m_axis_tuser = out_flat;

`ifndef ASSERT_OFF
  // a flat result always carries a zero mapping
  a_flat_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[MAPPED_W-1:0] == '0))
    else $error("flat result with non-zero mapping");

  // mapping never exceeds full scale
  a_map_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[MAPPED_W-1:0] <= MAPPED_W'(1 << MAP_SCALE_LOG2)))
    else $error("mapping above full scale");

  // running extremes stay ordered
  a_min_max: assert property (@(posedge clk) disable iff (rst)
    run_min <= run_max)
    else $error("running minimum above maximum");

  // divider never runs with a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (diff_r != '0))
    else $error("division by zero span");
`endif

endmodule
